// ===== sv/pes_pkg.sv =====
package pes_pkg;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_STIME  = 3'd2,
        REQ_SCYCLE = 3'd3,
        REQ_SREP   = 3'd4,
        REQ_ADV    = 3'd5
    } t_req;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_BADCYC   = 3'd2;
    localparam logic [2:0] ST_PAST     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_NOTHING  = 3'd5;

    localparam int MaxResults = 16;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [31:0]        event_id;
        logic signed [63:0] target_time;
        logic signed [63:0] cycle_time;
        logic signed [31:0] repeat_count;
    } t_req_item;

    typedef struct packed {
        logic [31:0]        out_event_id;
        logic signed [63:0] fire_time;
        logic [2:0]         status;
        logic               last;
    } t_res_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_MIN,
        S_PICK,
        S_FIRE,
        S_DONE
    } t_state;

    // saturating signed 64-bit add
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) begin
            sat_add = {1'b0, {63{1'b1}}};
        end else if (a[63] && b[63] && !s[63]) begin
            sat_add = {1'b1, 63'd0};
        end else begin
            sat_add = s;
        end
    endfunction

endpackage

// ===== sv/periodic_event_scheduler.sv =====
// a request other than advance scans every slot in S_SCAN, then acts and sets its result in S_EXEC
// a new request is accepted only in S_IDLE, once the previous one has finished and busy is low
// advance: S_MIN scans every slot for the earliest due time; each fired event takes an S_PICK scan
// and S_FIRE, a final S_PICK scan ends (S_DONE at MaxResults); each result goes out one event late
// results are single-cycle strobes; the receiver cannot stall
// synchronous active-low reset clears slot valid bits, current time and id counter
module periodic_event_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pes_pkg::t_req_item   i_req,
    output logic                 o_valid,
    output pes_pkg::t_res_item   o_res
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0]   r_valid, n_valid;
    logic [SLOTS-1:0]   r_fired, n_fired;
    logic [31:0]        mem_id [SLOTS];
    logic signed [63:0] mem_due [SLOTS];
    logic signed [63:0] mem_cyc [SLOTS];
    logic signed [31:0] mem_rep [SLOTS];

    pes_pkg::t_state    r_state, n_state;
    pes_pkg::t_req_item r_req, n_req;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_hit, n_hit;
    logic [IW-1:0]      r_sel, n_sel;
    logic               r_free, n_free;
    logic [IW-1:0]      r_fsl, n_fsl;
    logic signed [63:0] r_t, n_t;
    logic signed [63:0] r_now, n_now;
    logic [31:0]        r_lid, n_lid;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_ov, n_ov;
    pes_pkg::t_res_item r_res, n_res;
    logic [31:0]        r_cid, n_cid;
    pes_pkg::t_res_item r_pend, n_pend;

    // registered read of the slot under the scan pointer
    logic [IW-1:0]      rd_a;
    logic [31:0]        r_rid;
    logic signed [63:0] r_rdue, r_rcyc;
    logic signed [31:0] r_rrep;
    logic               r_rv, r_rf;

    // write port
    logic               we;
    logic [IW-1:0]      wa;
    logic [31:0]        wid;
    logic signed [63:0] wdue, wcyc;
    logic signed [31:0] wrep;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_id[wa]  <= wid;
            mem_due[wa] <= wdue;
            mem_cyc[wa] <= wcyc;
            mem_rep[wa] <= wrep;
        end
        r_rid  <= mem_id[rd_a];
        r_rdue <= mem_due[rd_a];
        r_rcyc <= mem_cyc[rd_a];
        r_rrep <= mem_rep[rd_a];
        r_rv   <= n_valid[rd_a];
        r_rf   <= n_fired[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pes_pkg::S_IDLE;
            r_valid <= '0;
            r_now   <= '0;
            r_lid   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_now   <= n_now;
            r_lid   <= n_lid;
            r_ov    <= n_ov;
        end
        r_fired <= n_fired;
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_hit   <= n_hit;
        r_sel   <= n_sel;
        r_free  <= n_free;
        r_fsl   <= n_fsl;
        r_t     <= n_t;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        r_cid   <= n_cid;
        r_pend  <= n_pend;
    end

    assign busy    = (r_state != pes_pkg::S_IDLE);
    assign o_valid = r_ov;
    assign o_res   = r_res;

    // sequencer: scan slots one per cycle, then act
    always_comb begin
        logic [IW-1:0] p;
        n_state = r_state; n_valid = r_valid; n_fired = r_fired; n_req = r_req;
        n_idx = r_idx; n_hit = r_hit; n_sel = r_sel; n_free = r_free; n_fsl = r_fsl;
        n_t = r_t; n_now = r_now; n_lid = r_lid; n_cnt = r_cnt; n_ov = 1'b0;
        n_res = r_res; n_cid = r_cid; n_pend = r_pend;
        we = 1'b0; wa = r_sel; wid = r_rid; wdue = r_rdue; wcyc = r_rcyc; wrep = r_rrep;
        rd_a = r_idx[IW-1:0];
        p = (r_idx == '0) ? '0 : IW'(r_idx - CW'(1));
        case (r_state)
            pes_pkg::S_IDLE: begin
                rd_a = '0;
                if (start) begin
                    n_req = i_req; n_idx = CW'(1); n_hit = 1'b0; n_free = 1'b0;
                    n_fired = '0; n_cnt = '0;
                    n_state = (i_req.req_type == pes_pkg::REQ_ADV) ? pes_pkg::S_MIN
                                                                   : pes_pkg::S_SCAN;
                end
            end
            pes_pkg::S_SCAN: begin
                // examine slot p read last cycle
                if (r_rv && r_rid == r_req.event_id && !r_hit) begin
                    n_hit = 1'b1; n_sel = p;
                end
                if (!r_rv && !r_free) begin
                    n_free = 1'b1; n_fsl = p;
                end
                if (r_idx == CW'(SLOTS)) begin
                    rd_a = n_hit ? n_sel : '0;
                    n_state = pes_pkg::S_EXEC;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            pes_pkg::S_EXEC: begin
                n_ov = 1'b1;
                n_res.fire_time = r_now;
                n_res.last = 1'b1;
                n_res.status = pes_pkg::ST_OK;
                n_res.out_event_id = r_req.event_id;
                n_state = pes_pkg::S_IDLE;
                case (r_req.req_type)
                    pes_pkg::REQ_ADD: begin
                        n_res.out_event_id = '0;
                        if (r_req.target_time < r_now) begin
                            n_res.status = pes_pkg::ST_PAST;
                        end else if (r_req.repeat_count != 0 && r_req.cycle_time <= 0) begin
                            n_res.status = pes_pkg::ST_BADCYC;
                        end else if (!r_free) begin
                            n_res.status = pes_pkg::ST_FULL;
                        end else begin
                            n_lid = r_lid + 32'd1;
                            n_res.out_event_id = n_lid;
                            n_valid[r_fsl] = 1'b1;
                            we = 1'b1; wa = r_fsl; wid = n_lid;
                            wdue = r_req.target_time; wcyc = r_req.cycle_time;
                            wrep = r_req.repeat_count;
                        end
                    end
                    pes_pkg::REQ_REMOVE, pes_pkg::REQ_STIME,
                    pes_pkg::REQ_SCYCLE, pes_pkg::REQ_SREP: begin
                        we = r_hit; wa = r_sel;
                        if (!r_hit) begin
                            n_res.status = pes_pkg::ST_UNKNOWN;
                        end else if (r_req.req_type == pes_pkg::REQ_REMOVE) begin
                            n_valid[r_sel] = 1'b0;
                        end else if (r_req.req_type == pes_pkg::REQ_STIME) begin
                            if (r_req.target_time < r_now) n_valid[r_sel] = 1'b0;
                            else wdue = r_req.target_time;
                        end else if (r_req.req_type == pes_pkg::REQ_SCYCLE) begin
                            if (r_rrep > 0 && r_req.cycle_time <= 0)
                                n_res.status = pes_pkg::ST_BADCYC;
                            else wcyc = r_req.cycle_time;
                        end else begin
                            if (r_req.repeat_count != 0 && r_rcyc <= 0)
                                n_res.status = pes_pkg::ST_BADCYC;
                            else wrep = r_req.repeat_count;
                        end
                    end
                    default: ;
                endcase
            end
            pes_pkg::S_MIN: begin
                // earliest due time over valid slots
                if (r_rv && (!r_hit || r_rdue < r_t)) begin
                    n_hit = 1'b1; n_t = r_rdue;
                end
                if (r_idx == CW'(SLOTS)) begin
                    if (!n_hit) begin
                        n_ov = 1'b1;
                        n_res.out_event_id = '0; n_res.fire_time = r_now;
                        n_res.status = pes_pkg::ST_NOTHING; n_res.last = 1'b1;
                        n_state = pes_pkg::S_IDLE;
                    end else begin
                        n_now = n_t; n_idx = CW'(1); n_free = 1'b0; rd_a = '0;
                        n_state = pes_pkg::S_PICK;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            pes_pkg::S_PICK: begin
                // lowest id among unfired slots due now (r_free: candidate found)
                if (r_rv && !r_rf && r_rdue == r_now) begin
                    if (!r_free || r_rid < r_cid) begin
                        n_free = 1'b1; n_sel = p; n_cid = r_rid;
                    end
                end
                if (r_idx == CW'(SLOTS)) begin
                    if (n_free) begin
                        rd_a = n_sel;
                        n_state = pes_pkg::S_FIRE;
                    end else begin
                        // nothing else due: the held result is the final one
                        n_ov = 1'b1;
                        n_res = r_pend;
                        n_res.last = 1'b1;
                        n_state = pes_pkg::S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            pes_pkg::S_FIRE: begin
                // emit previous held result, then hold this one
                if (r_cnt != '0) begin
                    n_ov = 1'b1;
                    n_res = r_pend;
                end
                n_pend.out_event_id = r_rid; n_pend.fire_time = r_now;
                n_pend.status = pes_pkg::ST_OK; n_pend.last = 1'b0;
                n_fired[r_sel] = 1'b1;
                we = 1'b1; wa = r_sel;
                if (r_rrep == 0) begin
                    n_valid[r_sel] = 1'b0;
                end else begin
                    if (r_rrep > 0) wrep = r_rrep - 32'sd1;
                    wdue = pes_pkg::sat_add(r_rdue, r_rcyc);
                end
                n_cnt = r_cnt + 5'd1;
                n_idx = CW'(1); n_free = 1'b0; rd_a = '0;
                n_state = (n_cnt == 5'(pes_pkg::MaxResults)) ? pes_pkg::S_DONE
                                                              : pes_pkg::S_PICK;
            end
            pes_pkg::S_DONE: begin
                // result limit reached: held result closes the transaction
                n_ov = 1'b1;
                n_res = r_pend;
                n_res.last = 1'b1;
                n_state = pes_pkg::S_IDLE;
            end
            default: n_state = pes_pkg::S_IDLE;
        endcase
    end
endmodule
